### rtl/core/lrsf_pkg.sv
// ----------------------------------------------------------------------------
// lrsf_pkg
// Shared widths, codes and interface structs of the rule score fitness block.
// ----------------------------------------------------------------------------
package lrsf_pkg;

  localparam int RULE_COUNT = 2048;
  localparam int IDX_W      = 11;
  localparam int FRAC_BITS  = 12;
  localparam int WEIGHT_W   = 16;
  localparam int SCORE_W    = 24;
  localparam int CNT_W      = 32;
  localparam int SUM_W      = 48;
  localparam int FIT_W      = 48;
  localparam int BIAS_W     = 16;
  localparam int CFG_IDX_W  = 1;

  // request codes
  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_HIT    = 2'd1;
  localparam logic [1:0] REQ_EMPTY  = 2'd2;
  localparam logic [1:0] REQ_FINISH = 2'd3;

  // verdict codes, also the index into the outcome counters
  localparam logic [1:0] VERD_TP = 2'd0;
  localparam logic [1:0] VERD_FN = 2'd1;
  localparam logic [1:0] VERD_FP = 2'd2;
  localparam logic [1:0] VERD_TN = 2'd3;

  // result kinds
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS   = 1'b1;

  localparam logic [SCORE_W-1:0] THRESH_RESET = SCORE_W'(5 << FRAC_BITS);
  localparam logic [BIAS_W-1:0]  BIAS_RESET   = BIAS_W'(2560);

  typedef logic [3:0][CNT_W-1:0] counts_t;

  typedef struct packed {
    counts_t          counts;
    logic [SUM_W-1:0] fn_sum;
    logic [SUM_W-1:0] fp_sum;
    logic [BIAS_W-1:0] bias;
  } fit_req_t;

  typedef struct packed {
    counts_t          counts;
    logic [FIT_W-1:0] fitness;
  } fit_res_t;

endpackage

### rtl/core/linear_rule_score_fitness_top.sv
// ----------------------------------------------------------------------------
// linear_rule_score_fitness_top
// Rule weight table, per-message scoring and outcome counting, fitness report.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one item per handshake:
//   weight writes, rule hits, empty messages and finish requests. Output
//   channel (out_valid_o/out_ready_i) returns one verdict per finished
//   message and one summary per finish item.
//   Items enter at one per cycle while in_ready_o is high. A weight write
//   lands at acceptance, so a hit right behind it sees the new weight. The
//   weight RAM read is registered at acceptance and the score is accumulated
//   in the stage after it, from which a verdict enters the output register
//   unless the output or a summary in flight holds it. A finish item hands
//   the counts to the fitness unit, which takes the log of each sum above
//   3.0 by a bit-serial normalize and 24 squarings on a single 31x31
//   multiplier before the summary reaches the output register. Verdict items
//   behind it wait until the summary reaches the output register.
//   While out_ready_i is low and a result is held, the next result-producing
//   item still enters, then holds in_ready_o low until the output drains.
//   Reset clears counts, sums, score and the output valid; threshold and bias
//   return to their defaults. The weight table is not cleared and must be written
//   before its rules are hit.
// ----------------------------------------------------------------------------
module linear_rule_score_fitness_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         req_type_i,
  input  logic [lrsf_pkg::IDX_W-1:0]         rule_index_i,
  input  logic signed [lrsf_pkg::WEIGHT_W-1:0] weight_value_i,
  input  logic                               is_spam_label_i,
  input  logic                               last_hit_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               result_kind_o,
  output logic signed [lrsf_pkg::SCORE_W-1:0] message_score_o,
  output logic [1:0]                         verdict_o,
  output logic [lrsf_pkg::CNT_W-1:0]         true_pos_count_o,
  output logic [lrsf_pkg::CNT_W-1:0]         false_neg_count_o,
  output logic [lrsf_pkg::CNT_W-1:0]         false_pos_count_o,
  output logic [lrsf_pkg::CNT_W-1:0]         true_neg_count_o,
  output logic signed [lrsf_pkg::FIT_W-1:0]  fitness_o,
  input  logic                               cfg_we_i,
  input  logic [lrsf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lrsf_pkg::SCORE_W-1:0]       cfg_wdata_i
);
  import lrsf_pkg::*;

  // configuration
  logic [SCORE_W-1:0] thresh_q;
  logic [BIAS_W-1:0]  bias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
      bias_q   <= BIAS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESH: thresh_q <= cfg_wdata_i;
        CFG_BIAS:   bias_q   <= cfg_wdata_i[BIAS_W-1:0];
        default:    ;
      endcase
    end
  end

  // weight RAM: write and read at acceptance
  logic [WEIGHT_W-1:0] wt_mem [RULE_COUNT];
  logic [WEIGHT_W-1:0] wt_rd_q;
  logic                in_fire;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (req_type_i == REQ_WRITE) begin
        wt_mem[rule_index_i] <= weight_value_i;
      end
      wt_rd_q <= wt_mem[rule_index_i];
    end
  end

  // scoring stage
  logic       s1_valid_q;
  logic [1:0] s1_type_q;
  logic       s1_spam_q, s1_last_q;

  logic [SCORE_W-1:0] run_q, run_d;
  counts_t            counts_q, counts_d;
  logic [SUM_W-1:0]   fn_sum_q, fn_sum_d, fp_sum_q, fp_sum_d;

  logic [SCORE_W:0]   hit_ext;
  logic [SCORE_W-1:0] hit_sat, score;
  logic               s1_hit, s1_res, s1_fin, s1_go, s1_fire_res;
  logic               above, out_free;
  logic [1:0]         verd;

  logic     fit_start, fit_busy, fit_res_valid, fit_take;
  fit_req_t fit_req;
  fit_res_t fit_res;

  function automatic logic [SUM_W-1:0] sum_sat(input logic [SUM_W-1:0]   acc,
                                               input logic [SCORE_W-1:0] add);
    logic [SUM_W:0] s;
    s = {acc[SUM_W-1], acc} + {{(SUM_W-SCORE_W+1){add[SCORE_W-1]}}, add};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sum_sat = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = s[SUM_W-1:0];
    end
  endfunction

  always_comb begin
    hit_ext = {run_q[SCORE_W-1], run_q}
            + {{(SCORE_W+1-WEIGHT_W){wt_rd_q[WEIGHT_W-1]}}, wt_rd_q};
    if (hit_ext[SCORE_W] != hit_ext[SCORE_W-1]) begin
      hit_sat = hit_ext[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}}
                                 : {1'b0, {(SCORE_W-1){1'b1}}};
    end else begin
      hit_sat = hit_ext[SCORE_W-1:0];
    end

    s1_hit   = s1_type_q == REQ_HIT;
    s1_res   = s1_valid_q && ((s1_hit && s1_last_q) || s1_type_q == REQ_EMPTY);
    s1_fin   = s1_valid_q && s1_type_q == REQ_FINISH;
    out_free = !out_valid_o || out_ready_i;

    // verdicts and finish hold while a summary is in flight
    if (!s1_valid_q) begin
      s1_go = 1'b1;
    end else if (s1_res) begin
      s1_go = !fit_busy && out_free;
    end else if (s1_fin) begin
      s1_go = !fit_busy;
    end else begin
      s1_go = 1'b1;
    end
    s1_fire_res = s1_res && !fit_busy && out_free;
    fit_start   = s1_fin && !fit_busy;
    fit_take    = fit_res_valid && out_free;

    score = s1_hit ? hit_sat : run_q;
    above = $signed(score) >= $signed(thresh_q);
    if (s1_spam_q) begin
      verd = above ? VERD_TP : VERD_FN;
    end else begin
      verd = above ? VERD_FP : VERD_TN;
    end

    run_d    = run_q;
    counts_d = counts_q;
    fn_sum_d = fn_sum_q;
    fp_sum_d = fp_sum_q;
    if (s1_valid_q && s1_hit && !s1_last_q) begin
      run_d = hit_sat;
    end
    if (s1_fire_res) begin
      run_d = '0;
      if (counts_q[verd] != {CNT_W{1'b1}}) begin
        counts_d[verd] = counts_q[verd] + CNT_W'(1);
      end
      if (verd == VERD_FN) begin
        fn_sum_d = sum_sat(fn_sum_q, score);
      end
      if (verd == VERD_FP) begin
        fp_sum_d = sum_sat(fp_sum_q, score);
      end
    end
    if (fit_start) begin
      run_d    = '0;
      counts_d = '0;
      fn_sum_d = '0;
      fp_sum_d = '0;
    end
  end

  assign in_ready_o = s1_go;
  assign in_fire    = in_valid_i && s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      run_q      <= '0;
      counts_q   <= '0;
      fn_sum_q   <= '0;
      fp_sum_q   <= '0;
    end else begin
      if (s1_go) begin
        s1_valid_q <= in_fire;
      end
      run_q    <= run_d;
      counts_q <= counts_d;
      fn_sum_q <= fn_sum_d;
      fp_sum_q <= fp_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_type_q <= req_type_i;
      s1_spam_q <= is_spam_label_i;
      s1_last_q <= last_hit_i;
    end
  end

  assign fit_req = '{counts: counts_q, fn_sum: fn_sum_q, fp_sum: fp_sum_q,
                     bias: bias_q};

  lrsf_fitness u_fitness (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (fit_start),
    .req_i       (fit_req),
    .take_i      (fit_take),
    .busy_o      (fit_busy),
    .res_valid_o (fit_res_valid),
    .res_o       (fit_res)
  );

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire_res || fit_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire_res) begin
      result_kind_o     <= KIND_VERDICT;
      message_score_o   <= score;
      verdict_o         <= verd;
      true_pos_count_o  <= '0;
      false_neg_count_o <= '0;
      false_pos_count_o <= '0;
      true_neg_count_o  <= '0;
      fitness_o         <= '0;
    end else if (fit_take) begin
      result_kind_o     <= KIND_SUMMARY;
      message_score_o   <= '0;
      verdict_o         <= VERD_TP;
      true_pos_count_o  <= fit_res.counts[VERD_TP];
      false_neg_count_o <= fit_res.counts[VERD_FN];
      false_pos_count_o <= fit_res.counts[VERD_FP];
      true_neg_count_o  <= fit_res.counts[VERD_TN];
      fitness_o         <= fit_res.fitness;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fit_start |=> (run_q == '0 && counts_q == '0 && fn_sum_q == '0 &&
                   fp_sum_q == '0))
    else $error("finish did not clear score, counts and sums");
  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_go) |=> $stable(wt_rd_q))
    else $error("weight read data changed under a stalled item");
  a_verdict_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_VERDICT) |->
      (fitness_o == '0 && true_pos_count_o == '0 && false_neg_count_o == '0 &&
       false_pos_count_o == '0 && true_neg_count_o == '0))
    else $error("verdict item carries summary fields");
`endif

endmodule

### rtl/core/lrsf_fitness.sv
// ----------------------------------------------------------------------------
// lrsf_fitness
// Sequential fitness unit: natural logs of the two sums above 3.0 by bit-serial normalize and
// repeated squaring on one 31x31 multiplier, then the weighted total.
// ----------------------------------------------------------------------------
module lrsf_fitness (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  lrsf_pkg::fit_req_t req_i,
  input  logic              take_i,
  output logic              busy_o,
  output logic              res_valid_o,
  output lrsf_pkg::fit_res_t res_o
);
  import lrsf_pkg::*;

  localparam int MANT_W   = 31;
  localparam int LOG_FRAC = 24;
  localparam int SQ_STEPS = 24;
  localparam int STEP_W   = 5;
  localparam int EXP_W    = 6;
  localparam int LOG2_W   = EXP_W + LOG_FRAC;
  localparam int LN2_W    = 30;
  localparam int PROD_W   = LOG2_W + LN2_W;
  localparam int RND_SH   = 54 - FRAC_BITS;
  localparam int LN_W     = 18;
  localparam int PB_W     = CNT_W + BIAS_W;
  localparam int LB_W     = LN_W + BIAS_W;
  localparam int TOT_W    = 56;

  localparam logic [LN2_W-1:0]  LN2_Q30   = LN2_W'(744261118);
  localparam logic [SUM_W-1:0]  LOG_FLOOR = SUM_W'(3) << FRAC_BITS;
  localparam logic [PROD_W-1:0] RND_HALF  = PROD_W'(1) << (RND_SH - 1);
  localparam logic [TOT_W-1:0]  FIT_MAX   =
    {{(TOT_W-FIT_W+1){1'b0}}, {(FIT_W-1){1'b1}}};
  localparam logic [TOT_W-1:0]  FIT_MIN   =
    {{(TOT_W-FIT_W+1){1'b1}}, {(FIT_W-1){1'b0}}};

  typedef enum logic [8:0] {
    FS_IDLE  = 9'b000000001,
    FS_CHECK = 9'b000000010,
    FS_NORM  = 9'b000000100,
    FS_SQR   = 9'b000001000,
    FS_MUL   = 9'b000010000,
    FS_RND   = 9'b000100000,
    FS_PROD  = 9'b001000000,
    FS_SUM   = 9'b010000000,
    FS_HOLD  = 9'b100000000
  } fit_state_e;

  fit_state_e        state_q, state_d;
  fit_req_t          req_q;
  logic              lane_q;
  logic [SUM_W-1:0]  x_q;
  logic [EXP_W-1:0]  k_q;
  logic [MANT_W-1:0] m_q;
  logic [LOG_FRAC-1:0] frac_q;
  logic [STEP_W-1:0] step_q;
  logic [PROD_W-1:0] prod_q;
  logic [LN_W-1:0]   lfp_q, lfn_q;
  logic [PB_W-1:0]   pb_q;
  logic [LB_W-1:0]   lb_q;
  logic [FIT_W-1:0]  fit_q;

  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     sq_top;
  logic [LOG2_W-1:0]   log2q;
  logic [PROD_W-1:0]   rnd_sum;
  logic [LN_W-1:0]     ln_val;
  logic                below_floor;
  logic [TOT_W-1:0]    total;
  logic [FIT_W-1:0]    fit_sat;

  always_comb begin
    sq          = m_q * m_q;
    sq_top      = sq[2*MANT_W-1 -: MANT_W+1];
    log2q       = {k_q - EXP_W'(FRAC_BITS), frac_q};
    rnd_sum     = prod_q + RND_HALF;
    ln_val      = rnd_sum[RND_SH +: LN_W];
    below_floor = $signed(x_q) <= $signed(LOG_FLOOR);
    // fn + fp*bias + L(fp_sum)*bias - L(fn_sum); both products are shifted as if they carried 8 fraction bits
    total   = (TOT_W'(req_q.counts[VERD_FN]) << FRAC_BITS)
            + (TOT_W'(pb_q) << (FRAC_BITS - 8))
            + (TOT_W'(lb_q) << (FRAC_BITS - 8))
            - TOT_W'(lfn_q);
    if ($signed(total) > $signed(FIT_MAX)) begin
      fit_sat = FIT_MAX[FIT_W-1:0];
    end else if ($signed(total) < $signed(FIT_MIN)) begin
      fit_sat = FIT_MIN[FIT_W-1:0];
    end else begin
      fit_sat = total[FIT_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FS_IDLE:  if (start_i) state_d = FS_CHECK;
      FS_CHECK: begin
        if (!below_floor) begin
          state_d = FS_NORM;
        end else if (lane_q) begin
          state_d = FS_PROD;
        end
      end
      FS_NORM:  if (x_q[SUM_W-1]) state_d = FS_SQR;
      FS_SQR:   if (step_q == STEP_W'(SQ_STEPS - 1)) state_d = FS_MUL;
      FS_MUL:   state_d = FS_RND;
      FS_RND:   state_d = lane_q ? FS_PROD : FS_CHECK;
      FS_PROD:  state_d = FS_SUM;
      FS_SUM:   state_d = FS_HOLD;
      FS_HOLD:  if (take_i) state_d = FS_IDLE;
      default:  state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      FS_IDLE: begin
        if (start_i) begin
          req_q  <= req_i;
          x_q    <= req_i.fp_sum;
          lane_q <= 1'b0;
        end
      end
      FS_CHECK: begin
        if (!below_floor) begin
          k_q <= EXP_W'(SUM_W - 1);
        end else if (!lane_q) begin
          lfp_q  <= '0;
          x_q    <= req_q.fn_sum;
          lane_q <= 1'b1;
        end else begin
          lfn_q <= '0;
        end
      end
      FS_NORM: begin
        // shift to the leading one; the mantissa is the top 31 bits
        if (x_q[SUM_W-1]) begin
          m_q    <= x_q[SUM_W-1 -: MANT_W];
          frac_q <= '0;
          step_q <= '0;
        end else begin
          x_q <= x_q << 1;
          k_q <= k_q - EXP_W'(1);
        end
      end
      FS_SQR: begin
        if (sq_top[MANT_W]) begin
          m_q <= sq_top[MANT_W:1];
        end else begin
          m_q <= sq_top[MANT_W-1:0];
        end
        frac_q <= {frac_q[LOG_FRAC-2:0], sq_top[MANT_W]};
        step_q <= step_q + STEP_W'(1);
      end
      FS_MUL: prod_q <= PROD_W'(log2q) * PROD_W'(LN2_Q30);
      FS_RND: begin
        if (!lane_q) begin
          lfp_q  <= ln_val;
          x_q    <= req_q.fn_sum;
          lane_q <= 1'b1;
        end else begin
          lfn_q <= ln_val;
        end
      end
      FS_PROD: begin
        pb_q <= PB_W'(req_q.counts[VERD_FP]) * PB_W'(req_q.bias);
        lb_q <= LB_W'(lfp_q) * LB_W'(req_q.bias);
      end
      FS_SUM:  fit_q <= fit_sat;
      FS_HOLD: ;
      default: ;
    endcase
  end

  assign busy_o      = state_q != FS_IDLE;
  assign res_valid_o = state_q == FS_HOLD;
  assign res_o       = '{counts: req_q.counts, fitness: fit_q};

`ifndef ASSERT_OFF
  a_sqr_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FS_SQR |-> step_q < STEP_W'(SQ_STEPS))
    else $error("squaring step count ran past the last step");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == FS_IDLE)
    else $error("fitness start while unit busy");
  a_take_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> state_q == FS_HOLD)
    else $error("fitness result taken while none held");
`endif

endmodule

### tb/linear_rule_score_fitness_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_rule_score_fitness_top_test
// Self-checking bench for the rule score fitness block.
// A directed table covers reset values, weight extremes and message corner
// cases. Score saturation in both directions runs next. Random labelled
// messages then run under several threshold and bias settings. Each result is
// checked field by field against the table's expected values or a score and fitness
// predictor kept in this bench, with random stalls on both channels.
// ----------------------------------------------------------------------------
module linear_rule_score_fitness_top_test;
  import lrsf_pkg::*;

  localparam int CLK_HALF    = 2;
  localparam int SETTLE      = 200;  // one fitness pass plus pipeline slack
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 120;
  localparam int SAT_HITS    = 260;
  localparam int LN_SHIFT    = 54 - FRAC_BITS;
  localparam longint unsigned LN2_Q30 = 64'd744261118;
  localparam longint MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint MIN48 = -MAX48 - 1;
  localparam longint MAX24 = 64'sd8388607;
  localparam longint MIN24 = -MAX24 - 1;
  localparam logic [IDX_W-1:0] SAT_UP   = 11'd5;
  localparam logic [IDX_W-1:0] SAT_DOWN = 11'd6;

  typedef struct packed {
    logic               kind;
    logic [SCORE_W-1:0] score;
    logic [1:0]         verd;
    logic [CNT_W-1:0]   tp;
    logic [CNT_W-1:0]   fn;
    logic [CNT_W-1:0]   fp;
    logic [CNT_W-1:0]   tn;
    logic [FIT_W-1:0]   fit;
  } report_t;

  typedef struct packed {
    logic [1:0]          req;
    logic [IDX_W-1:0]    idx;
    logic [WEIGHT_W-1:0] wt;
    logic                spam;
    logic                last;
    logic                typed;
    report_t             want;
  } stim_row_t;

  localparam stim_row_t DIRECTED [21] = '{
    // empty messages right after reset, their summary, then a cleared summary
    '{REQ_EMPTY,  11'd0,    16'h0000, 1'b0, 1'b0, 1'b1,
      '{KIND_VERDICT, 24'd0, VERD_TN, 32'd0, 32'd0, 32'd0, 32'd0, 48'd0}},
    '{REQ_EMPTY,  11'd0,    16'h0000, 1'b1, 1'b0, 1'b1,
      '{KIND_VERDICT, 24'd0, VERD_FN, 32'd0, 32'd0, 32'd0, 32'd0, 48'd0}},
    '{REQ_FINISH, 11'd0,    16'h0000, 1'b0, 1'b0, 1'b1,
      '{KIND_SUMMARY, 24'd0, 2'd0, 32'd0, 32'd1, 32'd0, 32'd1, 48'd4096}},
    '{REQ_FINISH, 11'd2047, 16'hFFFF, 1'b1, 1'b1, 1'b1,
      '{KIND_SUMMARY, 24'd0, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 48'd0}},
    // weight extremes at the index extremes
    '{REQ_WRITE,  11'd0,    16'h7FFF, 1'b1, 1'b1, 1'b0, '0},
    '{REQ_WRITE,  11'd2047, 16'h8000, 1'b0, 1'b0, 1'b0, '0},
    '{REQ_WRITE,  11'd1023, 16'h0A3D, 1'b0, 1'b1, 1'b0, '0},
    '{REQ_HIT,    11'd0,    16'h0000, 1'b1, 1'b0, 1'b0, '0},
    '{REQ_HIT,    11'd0,    16'h0000, 1'b1, 1'b1, 1'b1,
      '{KIND_VERDICT, 24'd65534, VERD_TP, 32'd0, 32'd0, 32'd0, 32'd0, 48'd0}},
    '{REQ_HIT,    11'd2047, 16'h0000, 1'b0, 1'b1, 1'b1,
      '{KIND_VERDICT, 24'hFF8000, VERD_TN, 32'd0, 32'd0, 32'd0, 32'd0, 48'd0}},
    // empty item closes a partly scored message with its running score
    '{REQ_HIT,    11'd0,    16'h0000, 1'b0, 1'b0, 1'b0, '0},
    '{REQ_EMPTY,  11'd0,    16'h0000, 1'b0, 1'b0, 1'b0, '0},
    // weight rewritten inside a message
    '{REQ_HIT,    11'd0,    16'h0000, 1'b0, 1'b0, 1'b0, '0},
    '{REQ_WRITE,  11'd0,    16'd100,  1'b0, 1'b0, 1'b0, '0},
    '{REQ_HIT,    11'd0,    16'h0000, 1'b0, 1'b1, 1'b0, '0},
    // finish drops the pending message
    '{REQ_HIT,    11'd1023, 16'h0000, 1'b1, 1'b0, 1'b0, '0},
    '{REQ_FINISH, 11'd0,    16'h0000, 1'b0, 1'b0, 1'b0, '0},
    '{REQ_EMPTY,  11'd0,    16'h0000, 1'b1, 1'b0, 1'b0, '0},
    '{REQ_HIT,    11'd2047, 16'h0000, 1'b1, 1'b1, 1'b0, '0},
    '{REQ_HIT,    11'd1023, 16'h0000, 1'b0, 1'b1, 1'b0, '0},
    '{REQ_FINISH, 11'd0,    16'h0000, 1'b0, 1'b0, 1'b0, '0}
  };

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [1:0]                 req_type_i;
  logic [IDX_W-1:0]           rule_index_i;
  logic signed [WEIGHT_W-1:0] weight_value_i;
  logic                       is_spam_label_i;
  logic                       last_hit_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic                       result_kind_o;
  logic signed [SCORE_W-1:0]  message_score_o;
  logic [1:0]                 verdict_o;
  logic [CNT_W-1:0]           true_pos_count_o;
  logic [CNT_W-1:0]           false_neg_count_o;
  logic [CNT_W-1:0]           false_pos_count_o;
  logic [CNT_W-1:0]           true_neg_count_o;
  logic signed [FIT_W-1:0]    fitness_o;
  logic                       cfg_we_i;
  logic [CFG_IDX_W-1:0]       cfg_idx_i;
  logic [SCORE_W-1:0]         cfg_wdata_i;

  // predictor state
  logic signed [WEIGHT_W-1:0] rule_weight [RULE_COUNT];
  logic [CNT_W-1:0]           tally [4];
  longint                     open_score;
  longint                     fn_sum;
  longint                     fp_sum;
  longint                     threshold;
  longint unsigned            fp_bias;

  bit          rule_loaded [RULE_COUNT];
  int unsigned loaded_rules [$];
  report_t     pending_reports [$];

  bit steady_run   = 1'b0;
  bit hold_off_req = 1'b0;
  int errors        = 0;
  int items_sent    = 0;
  int verdicts      = 0;
  int summaries     = 0;
  int settings_used = 0;

  linear_rule_score_fitness_top DUT (.*);

  always #(CLK_HALF) clk_i = ~clk_i;

  function automatic longint saturate(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // ln of a value above 3.0: log2 by repeated squaring, scaled by ln2
  function automatic longint unsigned natural_log_q(longint unsigned x);
    int              k;
    longint unsigned m;
    longint unsigned frac;
    longint unsigned log2q;
    k = 47;
    frac = 0;
    while (k > 0 && !x[k]) k--;
    if (k >= 30) m = x >> (k - 30);
    else m = x << (30 - k);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | (64'd1 << (23 - i));
      end
    end
    log2q = (longint'(k - FRAC_BITS) << 24) | frac;
    return (log2q * LN2_Q30 + (64'd1 << (LN_SHIFT - 1))) >> LN_SHIFT;
  endfunction

  function automatic longint unsigned log_above_three(longint s);
    if (s <= (longint'(3) << FRAC_BITS)) return 0;
    return natural_log_q(unsigned'(s));
  endfunction

  // advance the predictor by one item; return 1 when it yields a result
  function automatic bit score_item(input logic [1:0] req, input logic [IDX_W-1:0] idx,
                                    input logic [WEIGHT_W-1:0] wt, input logic spam,
                                    input logic last, output report_t rep);
    longint          fit;
    longint unsigned lfp;
    longint unsigned lfn;
    logic [1:0]      v;
    rep = '0;
    if (req == REQ_WRITE) begin
      rule_weight[idx] = wt;
      return 1'b0;
    end
    if (req == REQ_FINISH) begin
      lfp = log_above_three(fp_sum);
      lfn = log_above_three(fn_sum);
      fit = (longint'(tally[VERD_FN]) << FRAC_BITS)
          + longint'((tally[VERD_FP] * fp_bias) << (FRAC_BITS - 8))
          + longint'((lfp * fp_bias) << (FRAC_BITS - 8))
          - longint'(lfn);
      fit = saturate(fit, MIN48, MAX48);
      rep.kind = KIND_SUMMARY;
      rep.tp   = tally[VERD_TP];
      rep.fn   = tally[VERD_FN];
      rep.fp   = tally[VERD_FP];
      rep.tn   = tally[VERD_TN];
      rep.fit  = fit[FIT_W-1:0];
      foreach (tally[t]) tally[t] = '0;
      fn_sum = 0;
      fp_sum = 0;
      open_score = 0;
      return 1'b1;
    end
    if (req == REQ_HIT) begin
      open_score = saturate(open_score + longint'(rule_weight[idx]), MIN24, MAX24);
      if (!last) return 1'b0;
    end
    if (open_score >= threshold) v = spam ? VERD_TP : VERD_FP;
    else v = spam ? VERD_FN : VERD_TN;
    if (tally[v] != '1) tally[v] = tally[v] + 1'b1;
    if (v == VERD_FN) fn_sum = saturate(fn_sum + open_score, MIN48, MAX48);
    else if (v == VERD_FP) fp_sum = saturate(fp_sum + open_score, MIN48, MAX48);
    rep.kind  = KIND_VERDICT;
    rep.score = open_score[SCORE_W-1:0];
    rep.verd  = v;
    open_score = 0;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [FIT_W-1:0] want,
                             input logic [FIT_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // offer one item, hold it until accepted, then queue its prediction
  task automatic offer_item(input logic [1:0] req, input logic [IDX_W-1:0] idx,
                            input logic [WEIGHT_W-1:0] wt, input logic spam,
                            input logic last, input bit typed = 1'b0,
                            input report_t typed_rep = '0);
    report_t rep;
    if (!steady_run && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 13);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= req;
    rule_index_i    <= idx;
    weight_value_i  <= wt;
    is_spam_label_i <= spam;
    last_hit_i      <= last;
    do @(posedge clk_i); while (!in_ready_o);
    if (req == REQ_WRITE && !rule_loaded[idx]) begin
      rule_loaded[idx] = 1'b1;
      loaded_rules.push_back(idx);
    end
    if (score_item(req, idx, wt, spam, last, rep))
      pending_reports.push_back(typed ? typed_rep : rep);
    items_sent++;
  endtask

  // hold the input until every result is back and the fitness unit is done
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [SCORE_W-1:0] thr, input logic [BIAS_W-1:0] bias);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_THRESH;
    cfg_wdata_i <= thr;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_BIAS;
    cfg_wdata_i <= SCORE_W'(bias);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    threshold = longint'(signed'(thr));
    fp_bias   = bias;
    settings_used++;
  endtask

  initial begin : result_side
    report_t want;
    int      hold;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i) begin
        if (pending_reports.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, expected none, got kind %0b",
                   $time, result_kind_o);
        end else begin
          want = pending_reports.pop_front();
          check_field("result_kind", want.kind, result_kind_o);
          check_field("message_score", want.score, unsigned'(message_score_o));
          check_field("verdict", want.verd, verdict_o);
          check_field("true_pos_count", want.tp, true_pos_count_o);
          check_field("false_neg_count", want.fn, false_neg_count_o);
          check_field("false_pos_count", want.fp, false_pos_count_o);
          check_field("true_neg_count", want.tn, true_neg_count_o);
          check_field("fitness", want.fit, unsigned'(fitness_o));
          if (want.kind == KIND_SUMMARY) summaries++;
          else verdicts++;
        end
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold != 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady_run || ($urandom_range(99) >= 13);
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [SCORE_W-1:0] thr;
    logic [BIAS_W-1:0]  bias;
    int                 start;
    int                 pick;
    int                 len;
    logic               spam;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    req_type_i      = REQ_WRITE;
    rule_index_i    = '0;
    weight_value_i  = '0;
    is_spam_label_i = 1'b0;
    last_hit_i      = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_THRESH;
    cfg_wdata_i     = '0;
    foreach (rule_weight[r]) rule_weight[r] = '0;
    foreach (tally[t]) tally[t] = '0;
    open_score = 0;
    fn_sum     = 0;
    fp_sum     = 0;
    threshold  = longint'(signed'(THRESH_RESET));
    fp_bias    = BIAS_RESET;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < $size(DIRECTED); r++)
      offer_item(DIRECTED[r].req, DIRECTED[r].idx, DIRECTED[r].wt, DIRECTED[r].spam,
                 DIRECTED[r].last, DIRECTED[r].typed, DIRECTED[r].want);
    settle_block();

    // drive the running score into both rails against the top threshold
    apply_settings(24'h7FFFFF, 16'hFFFF);
    offer_item(REQ_WRITE, SAT_UP, 16'h7FFF, 1'b0, 1'b0);
    offer_item(REQ_WRITE, SAT_DOWN, 16'h8000, 1'b0, 1'b0);
    for (int i = 0; i < SAT_HITS; i++)
      offer_item(REQ_HIT, SAT_UP, 16'($urandom), 1'b0, i == SAT_HITS - 1);
    for (int i = 0; i < SAT_HITS; i++)
      offer_item(REQ_HIT, SAT_DOWN, 16'($urandom), 1'b1, i == SAT_HITS - 1);
    offer_item(REQ_FINISH, 11'($urandom), 16'($urandom), 1'b0, 1'b1);
    settle_block();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          thr  = 24'h800000;
          bias = 16'h0000;
        end
        1: begin
          thr  = 24'h000000;
          bias = 16'($urandom);
        end
        2: begin
          thr  = 24'($urandom_range(262143)) - 24'd131072;
          bias = BIAS_RESET;
        end
        3: begin
          thr  = 24'($urandom);
          bias = 16'($urandom);
        end
        default: begin
          thr  = THRESH_RESET;
          bias = 16'hFFFF;
        end
      endcase
      apply_settings(thr, bias);
      steady_run = (ph == 2);
      // stall the result side while items keep coming
      if (ph == 1) hold_off_req = 1'b1;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 12 || loaded_rules.size() < 8) begin
          offer_item(REQ_WRITE, 11'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
        end else if (pick < 20) begin
          offer_item(REQ_EMPTY, 11'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
        end else if (pick < 25) begin
          offer_item(REQ_FINISH, 11'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
        end else begin
          len  = $urandom_range(8, 1);
          spam = 1'($urandom);
          for (int h = 0; h < len; h++) begin
            if ($urandom_range(99) < 4)
              offer_item(REQ_WRITE, 11'($urandom), 16'($urandom), spam, 1'($urandom));
            if ($urandom_range(99) < 2) begin
              // abandon the message with a finish
              offer_item(REQ_FINISH, 11'($urandom), 16'($urandom), spam, 1'($urandom));
              break;
            end
            if (h == len - 1 && $urandom_range(99) < 10)
              offer_item(REQ_EMPTY, 11'($urandom), 16'($urandom), spam, 1'($urandom));
            else
              offer_item(REQ_HIT, 11'(loaded_rules[$urandom_range(loaded_rules.size() - 1)]),
                         16'($urandom), spam, h == len - 1);
          end
        end
      end
      steady_run = 1'b0;
      settle_block();
    end

    $display("Ran %0d items: %0d message verdicts and %0d summaries checked",
             items_sent, verdicts, summaries);
    $display("Covered %0d register settings, score rails both ways, stalls on both sides",
             settings_used);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
